>>> rtl/core/tgm_pkg.sv
// Shared constants, types and the quarter-wave cosine table of the tremolo gain modulator.
package tgm_pkg;

	localparam int CHANNELS       = 4;
	localparam int SAMPLE_BITS    = 24;
	localparam int COS_TABLE_BITS = 10;

	localparam int QTR_STEPS   = 1 << COS_TABLE_BITS;
	localparam int ROM_AW      = COS_TABLE_BITS + 1;
	localparam int GAIN_BITS   = 16;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int PLEN_BITS   = 21;
	localparam int PHASE_BITS  = 32;
	localparam int DEPTH_BITS  = 16;
	localparam int CHAN_BITS   = 3;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	// register indexes on the configuration port
	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;
	localparam logic [1:0] REG_CHANS  = 2'd3;

	typedef logic [GAIN_BITS-1:0] cos_tab_t [0:QTR_STEPS];

	typedef struct packed {
		logic accept;
		logic cfg_clear;
		logic gain_step;
		logic mul_step;
	} tgm_ctl_t;

	// Q15 cosine over a quarter turn: Taylor series through x^10 in Q30, rounding
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t           tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		for (int k = 0; k <= QTR_STEPS; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = ONE_Q30;
			sum  = $signed(ONE_Q30);
			term = ((term * x2) >> 30) / 64'd2;
			sum  = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd12;
			sum  = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd30;
			sum  = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd56;
			sum  = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd90;
			sum  = sum - $signed(term);
			if (sum < 0) sum = 64'sd0;
			if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
			tab[k] = GAIN_BITS'((64'(sum) + 64'd16384) >> 15);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

>>> rtl/core/tgm_lfo.sv
// Frame counter, phase accumulator, cosine lookup and gain computation.
module tgm_lfo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tgm_pkg::tgm_ctl_t                 ctl,
	input  logic [tgm_pkg::PLEN_BITS-1:0]     plen,
	input  logic [tgm_pkg::PHASE_BITS-1:0]    pstep,
	input  logic [tgm_pkg::DEPTH_BITS-1:0]    depth,
	output logic [tgm_pkg::GAIN_BITS-1:0]     gain
);
	import tgm_pkg::*;

	logic [PLEN_BITS-1:0]  count_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PLEN_BITS-1:0]  count_inc;
	logic [PLEN_BITS-1:0]  period;
	logic                  wrap;
	logic [1:0]            quad;
	logic [COS_TABLE_BITS-1:0] idx;
	logic [ROM_AW-1:0]     rom_addr;
	logic                  neg;
	logic [GAIN_BITS-1:0]  cos_s1;
	logic                  neg_s1;
	logic [GAIN_BITS:0]    diff;
	logic [32:0]           drop_prod;
	logic [GAIN_BITS-1:0]  gain_s2;

	assign count_inc = count_q + PLEN_BITS'(1);
	assign period    = (plen == '0) ? PLEN_BITS'(1) : plen;
	assign wrap      = (count_inc >= period) || (count_inc == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (ctl.cfg_clear) begin
			count_q <= '0;
			phase_q <= '0;
		end else if (ctl.accept) begin
			count_q <= wrap ? '0 : count_inc;
			phase_q <= wrap ? '0 : phase_q + pstep;
		end
	end

	// fold the quadrant onto the quarter-wave table
	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx      = phase_q[PHASE_BITS-3 -: COS_TABLE_BITS];
	assign neg      = (quad == 2'd1) || (quad == 2'd2);
	assign rom_addr = quad[0] ? ROM_AW'(QTR_STEPS) - {1'b0, idx} : {1'b0, idx};

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cos_s1 <= COS_TAB[rom_addr];
			neg_s1 <= neg;
		end
	end

	// drop = ((1 - cos) * depth + half) >> 17, all in Q15 / Q0.16
	assign diff      = neg_s1 ? (17'd32768 + {1'b0, cos_s1}) : (17'd32768 - {1'b0, cos_s1});
	assign drop_prod = 33'(diff) * 33'(depth) + 33'd65536;

	always_ff @(posedge clk) begin
		if (ctl.gain_step)
			gain_s2 <= GAIN_BITS'(32768) - drop_prod[32:17];
	end

	assign gain = gain_s2;

endmodule

>>> rtl/core/tgm_lane.sv
// One channel lane: holds a sample and scales it by the gain with rounding.
module tgm_lane (
	input  logic                                 clk,
	input  tgm_pkg::tgm_ctl_t                    ctl,
	input  logic                                 en,
	input  logic signed [tgm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [tgm_pkg::GAIN_BITS-1:0]        gain,
	output logic signed [tgm_pkg::SAMPLE_BITS-1:0] res
);
	import tgm_pkg::*;

	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          en_s1;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [SAMPLE_BITS-1:0] res_s3;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			sample_s1 <= sample;
			en_s1     <= en;
		end
	end

	assign prod = PROD_BITS'(sample_s1) * $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, gain})
	            + PROD_BITS'(16384);

	always_ff @(posedge clk) begin
		if (ctl.mul_step)
			res_s3 <= en_s1 ? prod[SAMPLE_BITS+14:15] : '0;
	end

	assign res = res_s3;

endmodule

>>> rtl/core/tremolo_gain_modulator_unit.sv
// Top level of the tremolo gain modulator: register port, sequencing, lanes and output register.
//
//  channel   handshake            payload                         width
//  --------  -------------------  ------------------------------  ------------------
//  config    psel/penable/pready  paddr, pwdata, prdata           4 / 32 / 32
//  input     in_valid / in_stall  sample_0 .. sample_3            24 signed each
//  output    out_valid/out_stall  out_0 .. out_3, gain            24 signed, 16
//
// A frame passes from transfer to the next free input slot through cosine ROM
// read, gain multiply, lane multiply, then load into the output register.
// The block takes no new frame until the last one is loaded into the output register.
// in_stall is high while a frame is in flight; a waiting result blocks the final
// load and with it the next transfer. Reset clears control and the LFO state.
module tremolo_gain_modulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [23:0] sample_0,
	input  logic signed [23:0] sample_1,
	input  logic signed [23:0] sample_2,
	input  logic signed [23:0] sample_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [23:0] out_0,
	output logic signed [23:0] out_1,
	output logic signed [23:0] out_2,
	output logic signed [23:0] out_3,
	output logic [15:0] gain
);
	import tgm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GAIN = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [PLEN_BITS-1:0]  plen_q;
	logic [PHASE_BITS-1:0] pstep_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [CHAN_BITS-1:0]  chans_q;
	logic                  cfg_wr;

	logic [1:0]            step_q;
	logic                  accept;
	logic                  load;
	logic                  out_valid_q;
	tgm_ctl_t              ctl;

	logic signed [SAMPLE_BITS-1:0] samp [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] lane_res [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] out_q [CHANNELS];
	logic [GAIN_BITS-1:0]  gain_w;
	logic [GAIN_BITS-1:0]  gain_q;

	// Register port: always ready; a write lands on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= PLEN_BITS'(9600);
			pstep_q <= PHASE_BITS'(447392);
			depth_q <= DEPTH_BITS'(32768);
			chans_q <= CHAN_BITS'(2);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PERIOD: plen_q  <= pwdata[PLEN_BITS-1:0];
				REG_STEP:   pstep_q <= pwdata[PHASE_BITS-1:0];
				REG_DEPTH:  depth_q <= pwdata[DEPTH_BITS-1:0];
				REG_CHANS:  chans_q <= pwdata[CHAN_BITS-1:0];
				default:    plen_q  <= plen_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PERIOD: prdata = 32'(plen_q);
			REG_STEP:   prdata = pstep_q;
			REG_DEPTH:  prdata = 32'(depth_q);
			REG_CHANS:  prdata = 32'(chans_q);
			default:    prdata = '0;
		endcase
	end

	// Sequencer: one frame in flight; hold in ST_HOLD until the output register frees up.
	assign in_stall = (step_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load     = (step_q == ST_HOLD) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			case (step_q)
				ST_IDLE: if (accept) step_q <= ST_GAIN;
				ST_GAIN: step_q <= ST_MUL;
				ST_MUL:  step_q <= ST_HOLD;
				ST_HOLD: if (load) step_q <= ST_IDLE;
				default: step_q <= ST_IDLE;
			endcase
		end
	end

	// Any register write restarts the modulation period.
	assign ctl.accept    = accept;
	assign ctl.cfg_clear = cfg_wr;
	assign ctl.gain_step = (step_q == ST_GAIN);
	assign ctl.mul_step  = (step_q == ST_MUL);

	tgm_lfo u_lfo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.plen   (plen_q),
		.pstep  (pstep_q),
		.depth  (depth_q),
		.gain   (gain_w)
	);

	assign samp[0] = sample_0;
	assign samp[1] = sample_1;
	assign samp[2] = sample_2;
	assign samp[3] = sample_3;

	// One lane per channel; a lane beyond the channel count yields zero.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		tgm_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.en     (chans_q > CHAN_BITS'(g)),
			.sample (samp[g]),
			.gain   (gain_w),
			.res    (lane_res[g])
		);
	end

	// Merge: gather the lanes and the gain into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= lane_res;
			gain_q <= gain_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_0     = out_q[0];
	assign out_1     = out_q[1];
	assign out_2     = out_q[2];
	assign out_3     = out_q[3];
	assign gain      = gain_q;

endmodule
